>>> sv/vfc_pkg.sv
package vfc_pkg;

  localparam int HOR_SIZE_DEF = 16;
  localparam int VER_SIZE_DEF = 128;

  localparam logic [2:0] FACE_XM = 3'd0;
  localparam logic [2:0] FACE_XP = 3'd1;
  localparam logic [2:0] FACE_ZM = 3'd2;
  localparam logic [2:0] FACE_ZP = 3'd3;
  localparam logic [2:0] FACE_YM = 3'd4;
  localparam logic [2:0] FACE_YP = 3'd5;

  localparam logic [2:0] LAST_CORNER = 3'd5;

  typedef struct packed {
    logic       valid;
    logic [3:0] x;
    logic [6:0] y;
    logic [3:0] z;
    logic [7:0] id;
    logic [5:0] faces;
    logic [2:0] swap;
  } vfc_job_t;

  // Corner offset of one vertex of a face: bit 0 is dx, bit 1 dy, bit 2 dz.
  function automatic logic [2:0] corner_of(logic [2:0] code, logic [2:0] vtx);
    logic [17:0] row;
    unique case (code)
      FACE_XM: row = {3'd2, 3'd6, 3'd0, 3'd6, 3'd4, 3'd0};
      FACE_XP: row = {3'd7, 3'd3, 3'd5, 3'd3, 3'd1, 3'd5};
      FACE_ZM: row = {3'd3, 3'd2, 3'd1, 3'd2, 3'd0, 3'd1};
      FACE_ZP: row = {3'd6, 3'd7, 3'd4, 3'd7, 3'd5, 3'd4};
      FACE_YM: row = {3'd5, 3'd1, 3'd4, 3'd1, 3'd0, 3'd4};
      FACE_YP: row = {3'd6, 3'd2, 3'd7, 3'd2, 3'd3, 3'd7};
      default: row = '0;
    endcase
    return row[vtx*3 +: 3];
  endfunction

endpackage

>>> sv/vfc_ram.sv
module vfc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/vfc_emit.sv
module vfc_emit import vfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  vfc_job_t job,
  output logic     busy,
  output logic     out_valid,
  input  logic     out_ready,
  output logic [4:0] vert_x,
  output logic [7:0] vert_y,
  output logic [4:0] vert_z,
  output logic [2:0] face_code,
  output logic [7:0] face_block_id,
  output logic       last_vertex
);

  logic [5:0] pend;
  logic [2:0] vidx;
  logic [3:0] jx;
  logic [6:0] jy;
  logic [3:0] jz;
  logic [7:0] jid;
  logic [2:0] jswap;

  logic [2:0] slot;
  logic [1:0] axis;
  logic [2:0] code;
  logic [2:0] offs;
  logic [5:0] rest;
  logic       advance;

  assign busy = (pend != '0);

  always_comb begin
    slot = '0;
    for (int i = 5; i >= 0; i--) begin
      if (pend[i]) begin
        slot = 3'(i);
      end
    end
  end

  assign axis    = slot[2:1];
  assign code    = {axis, slot[0] ^ jswap[axis]};
  assign offs    = corner_of(code, vidx);
  assign rest    = pend & ~(6'b000001 << slot);
  assign advance = busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      vidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (vidx == LAST_CORNER) begin
          pend <= rest;
          vidx <= '0;
        end else begin
          vidx <= vidx + 3'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job.valid && !busy) begin
        pend <= job.faces;
        vidx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid && !busy) begin
      jx    <= job.x;
      jy    <= job.y;
      jz    <= job.z;
      jid   <= job.id;
      jswap <= job.swap;
    end
    if (advance) begin
      vert_x        <= 5'(jx) + 5'(offs[0]);
      vert_y        <= 8'(jy) + 8'(offs[1]);
      vert_z        <= 5'(jz) + 5'(offs[2]);
      face_code     <= code;
      face_block_id <= jid;
      last_vertex   <= (vidx == LAST_CORNER) && (rest == '0);
    end
  end

endmodule

>>> sv/voxel_face_cull_mesher_top.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   req_type, pos_x, pos_y, pos_z, voxel_id, voxel_opaque
// out      out_valid / out_ready vert_x, vert_y, vert_z, face_code, face_block_id, last_vertex
//
// A write request goes to the store in the cycle it is accepted.
// A mesh request reads the voxel and its six neighbors through the single read port of the
// store and decides the faces, then the emitter gives six vertices per visible face.
// Vertex output overlaps with the next request once the face list is handed to the emitter.
// After reset the store is cleared one entry per cycle, all 2**(2*clog2(HOR_SIZE) +
// clog2(VER_SIZE)) entries (32768 by default), while in_ready stays low.
// A stalled output holds the emitter and, once its face list is taken, the next request.
module voxel_face_cull_mesher_top import vfc_pkg::*; #(
  parameter int HOR_SIZE = HOR_SIZE_DEF,
  parameter int VER_SIZE = VER_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [3:0] pos_x,
  input  logic [6:0] pos_y,
  input  logic [3:0] pos_z,
  input  logic [7:0] voxel_id,
  input  logic       voxel_opaque,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] vert_x,
  output logic [7:0] vert_y,
  output logic [4:0] vert_z,
  output logic [2:0] face_code,
  output logic [7:0] face_block_id,
  output logic       last_vertex
);

  localparam int XW    = $clog2(HOR_SIZE);
  localparam int YW    = $clog2(VER_SIZE);
  localparam int AW    = 2 * XW + YW;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] RD_SELF = 3'd0;
  localparam logic [2:0] RD_XM   = 3'd1;
  localparam logic [2:0] RD_XP   = 3'd2;
  localparam logic [2:0] RD_ZM   = 3'd3;
  localparam logic [2:0] RD_ZP   = 3'd4;
  localparam logic [2:0] RD_YM   = 3'd5;
  localparam logic [2:0] RD_YP   = 3'd6;
  localparam logic [2:0] RD_DONE = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CULL  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0] clr_addr;
  logic [2:0]    rd_cnt;
  logic          rd_vld;
  logic [2:0]    rd_idx;
  logic [3:0]    qx;
  logic [6:0]    qy;
  logic [3:0]    qz;
  logic [7:0]    self_id;
  logic [5:0]    opq;

  logic          accept;
  logic          in_range;
  logic [7:0]    ix, iy, iz;
  logic [7:0]    ax, ay, az;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [8:0]    wr_data;
  logic [8:0]    rd_data;

  logic [5:0]    vis;
  logic [2:0]    swap;
  logic [5:0]    faces;
  vfc_job_t      job;
  logic          emit_busy;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = (9'(pos_x) < 9'(HOR_SIZE)) && (9'(pos_y) < 9'(VER_SIZE))
                 && (9'(pos_z) < 9'(HOR_SIZE));

  assign ix      = 8'(pos_x);
  assign iy      = 8'(pos_y);
  assign iz      = 8'(pos_z);
  assign in_addr = {ix[XW-1:0], iy[YW-1:0], iz[XW-1:0]};

  always_comb begin
    ax = 8'(qx);
    ay = 8'(qy);
    az = 8'(qz);
    unique case (rd_cnt)
      RD_XM:   ax = 8'(qx) - 8'd1;
      RD_XP:   ax = 8'(qx) + 8'd1;
      RD_ZM:   az = 8'(qz) - 8'd1;
      RD_ZP:   az = 8'(qz) + 8'd1;
      RD_YM:   ay = 8'(qy) - 8'd1;
      RD_YP:   ay = 8'(qy) + 8'd1;
      default: ;
    endcase
  end

  assign rd_addr = {ax[XW-1:0], ay[YW-1:0], az[XW-1:0]};
  assign rd_en   = (state == S_READ) && (rd_cnt != RD_DONE);

  assign wr_en   = (state == S_CLEAR) || (accept && !req_type && in_range);
  assign wr_addr = (state == S_CLEAR) ? clr_addr : in_addr;
  assign wr_data = (state == S_CLEAR) ? 9'd0 : {voxel_opaque, voxel_id};

  vfc_ram #(
    .WIDTH (9),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A face on the chunk boundary is always visible.
  assign vis[0] = (qx == 4'd0) || !opq[0];
  assign vis[1] = (9'(qx) == 9'(HOR_SIZE - 1)) || !opq[1];
  assign vis[2] = (qz == 4'd0) || !opq[2];
  assign vis[3] = (9'(qz) == 9'(HOR_SIZE - 1)) || !opq[3];
  assign vis[4] = (qy == 7'd0) || !opq[4];
  assign vis[5] = (9'(qy) == 9'(VER_SIZE - 1)) || !opq[5];

  // At the upper end of an axis the positive face is listed first.
  assign swap[0] = (9'(qx) == 9'(HOR_SIZE - 1));
  assign swap[1] = (9'(qz) == 9'(HOR_SIZE - 1));
  assign swap[2] = (9'(qy) == 9'(VER_SIZE - 1));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      faces[2*a]   = swap[a] ? vis[2*a+1] : vis[2*a];
      faces[2*a+1] = swap[a] ? vis[2*a]   : vis[2*a+1];
    end
  end

  always_comb begin
    job.valid = (state == S_CULL) && !emit_busy;
    job.x     = qx;
    job.y     = qy;
    job.z     = qz;
    job.id    = self_id;
    job.faces = (self_id != 8'd0) ? faces : 6'd0;
    job.swap  = swap;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE:  if (accept && req_type && in_range) state_next = S_READ;
      S_READ:  if (rd_cnt == RD_DONE) state_next = S_CULL;
      S_CULL:  if (!emit_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_cnt   <= RD_SELF;
      rd_vld   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_READ) begin
        rd_cnt <= rd_cnt + 3'd1;
      end else begin
        rd_cnt <= RD_SELF;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_cnt;
    if (accept) begin
      qx <= pos_x;
      qy <= pos_y;
      qz <= pos_z;
    end
    if (rd_vld) begin
      if (rd_idx == RD_SELF) begin
        self_id <= rd_data[7:0];
      end else begin
        opq[rd_idx - 3'd1] <= rd_data[8];
      end
    end
  end

  vfc_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .job           (job),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .vert_x        (vert_x),
    .vert_y        (vert_y),
    .vert_z        (vert_z),
    .face_code     (face_code),
    .face_block_id (face_block_id),
    .last_vertex   (last_vertex)
  );

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("output valid during store clear");

  a_read_only_in_read: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_READ) || (state == S_CULL))
    else $error("store read data returned outside a query");

  a_face_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (face_code <= FACE_YP))
    else $error("face code out of range");

  a_job_to_idle: assert property (@(posedge clk) disable iff (rst)
    job.valid |=> (state == S_IDLE) && emit_busy == $past(job.faces != 6'd0))
    else $error("face list not taken by emitter");

endmodule
